// File: src/register_pair_stack_cache_assert.svh
// Assertion macros for the register pair stack cache
`ifndef REGISTER_PAIR_STACK_CACHE_ASSERT_SVH
`define REGISTER_PAIR_STACK_CACHE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset
`define RPSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication
`define RPSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: src/rpsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpsc_pkg
// Types and constants shared by the register pair stack cache modules.
// ----------------------------------------------------------------------------
package rpsc_pkg;

  localparam int unsigned PairCountDef = 16;
  localparam int unsigned MaxDepthDef  = 15;
  localparam logic [3:0]  PairsResetVal = 4'd11;

  localparam logic [2:0] OP_INIT = 3'd0;
  localparam logic [2:0] OP_GETFREE = 3'd1;
  localparam logic [2:0] OP_PUSH = 3'd2;
  localparam logic [2:0] OP_POP = 3'd3;
  localparam logic [2:0] OP_END = 3'd4;

  localparam logic [2:0] ACT_NONE = 3'd0;
  localparam logic [2:0] ACT_SPILL_INT = 3'd1;
  localparam logic [2:0] ACT_SPILL_REF = 3'd2;
  localparam logic [2:0] ACT_RELOAD_INT = 3'd3;
  localparam logic [2:0] ACT_RELOAD_REF = 3'd4;
  localparam logic [2:0] ACT_MOVE = 3'd5;

  localparam logic [2:0] ERR_OK = 3'd0;
  localparam logic [2:0] ERR_PUSH = 3'd1;
  localparam logic [2:0] ERR_TARGET = 3'd2;
  localparam logic [2:0] ERR_SPILL = 3'd3;
  localparam logic [2:0] ERR_SPACE = 3'd4;

  localparam logic [1:0] K_ONSTACK = 2'd0;
  localparam logic [1:0] K_AVAIL = 2'd1;
  localparam logic [1:0] K_INUSE = 2'd2;
  localparam logic [1:0] K_DIS = 2'd3;

  typedef struct packed {
    logic [2:0] operation;
    logic [4:0] push_register;
    logic       stack_kind;
    logic       has_target;
    logic [4:0] target_register;
    logic       lightweight;
  } in_word_t;

  typedef struct packed {
    logic [4:0] result_register;
    logic [2:0] action;
    logic [4:0] action_register;
    logic [4:0] move_source_register;
    logic [2:0] error;
  } out_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       ref_tag;
    logic [3:0] depth;
  } status_t;

  // Datapath commands
  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_SCAN,
    CMD_APPLY,
    CMD_DEPTH_NEXT
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic       load;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic depth_done;
  } dp_stat_t;

endpackage

// File: src/rpsc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpsc_datapath
// Pair status registers, serial scan over the pairs and the update logic.
// ----------------------------------------------------------------------------
module rpsc_datapath #(
  parameter int unsigned PairCount = rpsc_pkg::PairCountDef,
  parameter int unsigned MaxDepth  = rpsc_pkg::MaxDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rpsc_pkg::dp_cmd_t   cmd_i,
  input  rpsc_pkg::in_word_t  word_i,
  input  logic [3:0]          pairs_i,
  output rpsc_pkg::dp_stat_t  stat_o,
  output rpsc_pkg::out_word_t result_o
);

  localparam int unsigned IdxW = (PairCount > 1) ? $clog2(PairCount) : 1;
  localparam logic [IdxW:0] LastIdx = (IdxW + 1)'(PairCount - 1);

  rpsc_pkg::status_t st_q [PairCount];
  rpsc_pkg::status_t st_d [PairCount];
  rpsc_pkg::in_word_t w_q;

  logic [IdxW:0] scan_q;
  logic [IdxW:0] scan_d;
  logic [4:0]    dep_q, dep_d;
  // scan findings
  logic          fa_v_q, fa_v_d;   // lowest available
  logic [IdxW-1:0] fa_q, fa_d;
  logic          ha_v_q, ha_v_d;   // highest available
  logic [IdxW-1:0] ha_q, ha_d;
  logic          dp_v_q, dp_v_d;   // deepest on stack
  logic [IdxW-1:0] dp_q, dp_d;
  logic [3:0]    dpd_q, dpd_d;
  logic          ad_v_q, ad_v_d;   // lowest at current depth
  logic [IdxW-1:0] ad_q, ad_d;
  logic [IdxW-1:0] cur;
  rpsc_pkg::status_t cs;
  rpsc_pkg::out_word_t res_q, res_d;

  assign cur = scan_q[IdxW-1:0];
  assign cs  = st_q[cur];

  // target decode
  logic       t_ok;
  logic [3:0] t_idx;
  always_comb begin
    t_ok = (w_q.target_register == 5'd18) || (w_q.target_register == 5'd20) ||
           (w_q.target_register == 5'd22) || (w_q.target_register == 5'd24) ||
           (w_q.target_register == 5'd26) || (w_q.target_register == 5'd30);
    t_idx = w_q.target_register[4:1];
    if ({1'b0, t_idx} >= 5'(PairCount)) t_ok = 1'b0;
  end

  logic [3:0] p_idx;
  logic       p_ok;
  assign p_idx = w_q.push_register[4:1];
  always_comb begin
    p_ok = 1'b0;
    if ({1'b0, p_idx} < 5'(PairCount)) begin
      p_ok = (st_q[p_idx[IdxW-1:0]].kind == rpsc_pkg::K_INUSE) ||
             (w_q.push_register == 5'd22) || (w_q.push_register == 5'd24);
    end
  end

  logic          m_found;
  logic [IdxW-1:0] m_idx;
  logic          pop_target;
  always_comb begin
    m_found = ad_v_q && (st_q[ad_q].ref_tag == w_q.stack_kind);
    m_idx = ad_q;
    pop_target = w_q.has_target;
  end

  assign stat_o.scan_done   = (scan_q == LastIdx);
  assign stat_o.depth_done  = !ad_v_q || m_found || (dep_q >= 5'd15);
  assign result_o = res_q;

  function automatic logic [4:0] reg_of(input logic [IdxW-1:0] i);
    reg_of = 5'({i, 1'b0});
  endfunction

  function automatic logic not_fixed(input logic [IdxW-1:0] i);
    not_fixed = (5'(i) != 5'd13) && (5'(i) != 5'd15);
  endfunction

  always_comb begin
    logic [IdxW-1:0] tt;
    logic [4:0] ii;
    st_d = st_q;
    scan_d = scan_q;
    dep_d = dep_q;
    fa_v_d = fa_v_q; fa_d = fa_q; ha_v_d = ha_v_q; ha_d = ha_q;
    dp_v_d = dp_v_q; dp_d = dp_q; dpd_d = dpd_q; ad_v_d = ad_v_q; ad_d = ad_q;
    res_d = res_q;
    tt = '0;
    ii = '0;
    unique case (cmd_i.cmd)
      rpsc_pkg::CMD_SCAN: begin
        // one pair per cycle
        if (cs.kind == rpsc_pkg::K_AVAIL) begin
          if (!fa_v_d) begin fa_v_d = 1'b1; fa_d = cur; end
          ha_v_d = 1'b1; ha_d = cur;
        end
        if (cs.kind == rpsc_pkg::K_ONSTACK) begin
          if (!dp_v_q || cs.depth > dpd_q) begin
            dp_v_d = 1'b1; dp_d = cur; dpd_d = cs.depth;
          end
          if (!ad_v_d && {1'b0, cs.depth} == dep_q) begin
            ad_v_d = 1'b1; ad_d = cur;
          end
        end
        if (scan_q != LastIdx) scan_d = scan_q + 1'b1;
      end
      rpsc_pkg::CMD_DEPTH_NEXT: begin
        dep_d = dep_q + 5'd1;
        scan_d = '0;
        ad_v_d = 1'b0;
      end
      rpsc_pkg::CMD_APPLY: begin
        res_d = '0;
        case (w_q.operation)
          rpsc_pkg::OP_INIT: begin
            for (int i = 0; i < PairCount; i++) begin
              st_d[i] = '{rpsc_pkg::K_DIS, 1'b0, 4'd0};
              if (i >= 2 && (i - 2) < int'(pairs_i))
                st_d[i] = '{rpsc_pkg::K_AVAIL, 1'b0, 4'd0};
              if (i == 9 && w_q.lightweight)
                st_d[i] = '{rpsc_pkg::K_DIS, 1'b0, 4'd0};
            end
          end
          rpsc_pkg::OP_GETFREE: begin
            if (fa_v_q) begin
              st_d[fa_q] = '{rpsc_pkg::K_INUSE, 1'b0, 4'd0};
              res_d.result_register = reg_of(fa_q);
            end else if (dp_v_q) begin
              res_d.action = st_q[dp_q].ref_tag ? rpsc_pkg::ACT_SPILL_REF
                                                : rpsc_pkg::ACT_SPILL_INT;
              res_d.action_register = reg_of(dp_q);
              res_d.result_register = reg_of(dp_q);
              st_d[dp_q] = '{rpsc_pkg::K_INUSE, 1'b0, 4'd0};
            end else begin
              res_d.error = rpsc_pkg::ERR_SPILL;
            end
          end
          rpsc_pkg::OP_PUSH: begin
            if (!p_ok) begin
              res_d.error = rpsc_pkg::ERR_PUSH;
            end else begin
              for (int i = 0; i < PairCount; i++) begin
                if (st_q[i].kind == rpsc_pkg::K_ONSTACK &&
                    {1'b0, st_q[i].depth} < 5'(MaxDepth))
                  st_d[i].depth = st_q[i].depth + 4'd1;
              end
              st_d[p_idx[IdxW-1:0]] = '{rpsc_pkg::K_ONSTACK, w_q.stack_kind, 4'd0};
            end
          end
          rpsc_pkg::OP_POP: begin
            if (pop_target && !t_ok) begin
              res_d.error = rpsc_pkg::ERR_TARGET;
            end else if (m_found) begin
              tt = pop_target ? t_idx[IdxW-1:0] : m_idx;
              for (int i = 0; i < PairCount; i++) begin
                if (st_q[i].kind == rpsc_pkg::K_ONSTACK &&
                    {1'b0, st_q[i].depth} > dep_q)
                  st_d[i].depth = st_q[i].depth - 4'd1;
              end
              if (tt != m_idx) begin
                res_d.action = rpsc_pkg::ACT_MOVE;
                res_d.action_register = reg_of(tt);
                res_d.move_source_register = reg_of(m_idx);
                st_d[m_idx] = '{rpsc_pkg::K_AVAIL, 1'b0, 4'd0};
              end
              if (not_fixed(tt)) st_d[tt] = '{rpsc_pkg::K_INUSE, 1'b0, 4'd0};
              res_d.result_register = reg_of(tt);
            end else if (!pop_target && !ha_v_q) begin
              res_d.error = rpsc_pkg::ERR_SPACE;
            end else begin
              tt = pop_target ? t_idx[IdxW-1:0] : ha_q;
              res_d.action = w_q.stack_kind ? rpsc_pkg::ACT_RELOAD_REF
                                            : rpsc_pkg::ACT_RELOAD_INT;
              res_d.action_register = reg_of(tt);
              res_d.result_register = reg_of(tt);
              if (not_fixed(tt)) st_d[tt] = '{rpsc_pkg::K_INUSE, 1'b0, 4'd0};
            end
          end
          rpsc_pkg::OP_END: begin
            for (int i = 0; i < PairCount; i++)
              if (st_q[i].kind == rpsc_pkg::K_INUSE)
                st_d[i] = '{rpsc_pkg::K_AVAIL, 1'b0, 4'd0};
          end
          default: ;
        endcase
        ii = '0;
      end
      default: ;
    endcase
    if (cmd_i.load) begin
      scan_d = '0; dep_d = '0;
      fa_v_d = 1'b0; ha_v_d = 1'b0; dp_v_d = 1'b0; ad_v_d = 1'b0; dpd_d = '0;
    end
    if (ii != '0) res_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PairCount; i++) st_q[i] <= '{rpsc_pkg::K_DIS, 1'b0, 4'd0};
      scan_q <= '0;
      dep_q <= '0;
      fa_v_q <= 1'b0; ha_v_q <= 1'b0; dp_v_q <= 1'b0; ad_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      scan_q <= scan_d;
      dep_q <= dep_d;
      fa_v_q <= fa_v_d; ha_v_q <= ha_v_d; dp_v_q <= dp_v_d; ad_v_q <= ad_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) w_q <= word_i;
    fa_q <= fa_d; ha_q <= ha_d; dp_q <= dp_d; dpd_q <= dpd_d; ad_q <= ad_d;
    res_q <= res_d;
  end

endmodule

// File: src/rpsc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpsc_ctrl
// Sequencer: load word, scan pairs, step depths for pop, apply, hand off.
// ----------------------------------------------------------------------------
module rpsc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  logic               pop_i,
  input  rpsc_pkg::dp_stat_t stat_i,
  output rpsc_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_DEPTH = 5'b00100,
    S_APPLY = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d = state_q;
    cmd_o.cmd = rpsc_pkg::CMD_NOP;
    cmd_o.load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.cmd = rpsc_pkg::CMD_SCAN;
        if (stat_i.scan_done) state_d = pop_i ? S_DEPTH : S_APPLY;
      end
      S_DEPTH: begin
        // try the next depth unless this one settles the pop or is the last depth
        if (stat_i.depth_done) begin
          state_d = S_APPLY;
        end else begin
          cmd_o.cmd = rpsc_pkg::CMD_DEPTH_NEXT;
          state_d = S_SCAN;
        end
      end
      S_APPLY: begin
        cmd_o.cmd = rpsc_pkg::CMD_APPLY;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

endmodule

// File: src/register_pair_stack_cache.sv
`timescale 1ns / 1ps
// Init, get free, push and end of instruction each take one serial scan over the
// 16 pair status entries, then apply; a pop repeats the scan for each depth
// searched, up to sixteen depths.
// One word at a time; the next is taken the cycle after a result leaves.
// Reset: all pairs disabled, pairs_in_use 11, no word held.
// ----------------------------------------------------------------------------
// register_pair_stack_cache
// Top level: config register, sequencer and pair datapath.
// ----------------------------------------------------------------------------
`include "register_pair_stack_cache_assert.svh"
module register_pair_stack_cache #(
  parameter int unsigned PairCount = rpsc_pkg::PairCountDef,
  parameter int unsigned MaxDepth  = rpsc_pkg::MaxDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rpsc_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rpsc_pkg::out_word_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [3:0]          cfg_data_i
);

  logic [3:0] pairs_q;
  rpsc_pkg::dp_cmd_t  cmd;
  rpsc_pkg::dp_stat_t stat;
  logic pop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pairs_q <= rpsc_pkg::PairsResetVal;
    else if (cfg_we_i) pairs_q <= cfg_data_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd.load) pop_q <= (in_data_i.operation == rpsc_pkg::OP_POP);
  end

  rpsc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .pop_i(pop_q), .stat_i(stat), .cmd_o(cmd)
  );

  rpsc_datapath #(.PairCount(PairCount), .MaxDepth(MaxDepth)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .word_i(in_data_i), .pairs_i(pairs_q),
    .stat_o(stat), .result_o(out_data_o)
  );

  `RPSC_ASSERT_IMP(a_no_both, clk_i, rst_ni, in_ready_o, !out_valid_o)
  `RPSC_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `RPSC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)

endmodule
